FILE: hdl/avr_pkg.sv
// shared types, constants and the cordic arctangent table for the vector rotation unit
// no dependencies; imported by every module of the block
package avr_pkg;

    localparam int TRIG_W     = 32;   // cordic x/y, signed Q2.30
    localparam int ANGLE_Z_W  = 33;   // residual angle, 2^32 per turn, with headroom
    localparam int TRIG_FRAC  = 30;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 32'sh26DD3B6A;
    localparam logic signed [31:0]       ROUND_HALF      = 32'sh2000_0000;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [1:0]                  quad;
        logic signed [TRIG_W-1:0]    x;
        logic signed [TRIG_W-1:0]    y;
        logic signed [ANGLE_Z_W-1:0] z;
    } cordic_t;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            5'd24:   val = 32'h00000029;
            5'd25:   val = 32'h00000014;
            5'd26:   val = 32'h0000000A;
            5'd27:   val = 32'h00000005;
            5'd28:   val = 32'h00000003;
            5'd29:   val = 32'h00000001;
            5'd30:   val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/axis_vector_rotation_unit.sv
// top level: rotates a fixed-point 3d vector about a principal axis through a cordic pipeline
// depends on avr_pkg, avr_cordic_stage and avr_mac
//
// One transaction is accepted per cycle and each result is registered through one register
// per cordic micro-rotation, one quadrant and operand select register, and three multiply,
// sum and round/saturate registers. The whole
// pipeline advances together; when a result waits with m_ready low every stage holds and
// s_ready drops, so nothing is lost or repeated. Axis code 3 passes the vector through with
// saturated_flag low. Components are signed Q16.16, the angle is a binary angle where
// 2^ANGLE_WIDTH is one full turn.
module axis_vector_rotation_unit #(
    parameter int COMPONENT_WIDTH = 32,
    parameter int ANGLE_WIDTH     = 16,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_axis_select,
    input  logic [ANGLE_WIDTH-1:0]     s_turn_angle,
    input  logic signed [COMPONENT_WIDTH-1:0] s_in_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_in_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_in_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [COMPONENT_WIDTH-1:0] m_out_x,
    output logic signed [COMPONENT_WIDTH-1:0] m_out_y,
    output logic signed [COMPONENT_WIDTH-1:0] m_out_z,
    output logic                       m_saturated_flag
);
    import avr_pkg::*;

    localparam int CW    = COMPONENT_WIDTH;
    localparam int N     = CORDIC_STAGES;
    localparam int DEPTH = N + 4;
    localparam int QSEL  = N;          // index of the quadrant/select stage
    localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [1:0]           axis;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } payload_t;

    logic                  en;
    logic [DEPTH-1:0]      valid_reg;
    logic [DEPTH-1:0]      valid_next;
    payload_t              pay_reg [DEPTH];
    cordic_t               chain [N+1];

    logic signed [TRIG_W-1:0] cos_next, sin_next;
    logic signed [TRIG_W-1:0] cos_reg, sin_reg, nsin_reg;
    logic signed [CW-1:0]     a_next, b_next, a_reg, b_reg;
    logic signed [CW-1:0]     r0, r1;
    logic                     sat0, sat1;
    payload_t                 pay_out;

    assign en      = !valid_reg[DEPTH-1] || m_ready;
    // no transaction is taken while reset is held
    assign s_ready = en && aresetn;
    assign m_valid = valid_reg[DEPTH-1];

    assign valid_next = {valid_reg[DEPTH-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg[0] <= '{axis: s_axis_select, x: s_in_x, y: s_in_y, z: s_in_z};
            for (int k = 1; k < DEPTH; k++) begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    // quadrant from the top two angle bits, residual scaled to 2^32 per turn
    always_comb begin
        chain[0].quad = s_turn_angle[ANGLE_WIDTH-1 -: 2];
        chain[0].x    = CORDIC_GAIN_INV;
        chain[0].y    = '0;
        chain[0].z    = $signed(ANGLE_Z_W'(s_turn_angle[ANGLE_WIDTH-3:0]) << (32 - ANGLE_WIDTH));
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic
        avr_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .aclk  (aclk),
            .en    (en),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    always_comb begin
        case (chain[N].quad)
            2'd0: begin
                cos_next = chain[N].x;
                sin_next = chain[N].y;
            end
            2'd1: begin
                cos_next = -chain[N].y;
                sin_next = chain[N].x;
            end
            2'd2: begin
                cos_next = -chain[N].x;
                sin_next = -chain[N].y;
            end
            default: begin
                cos_next = chain[N].y;
                sin_next = -chain[N].x;
            end
        endcase
    end

    // rotated pair (a, b): (y, z) about x, (z, x) about y, (x, y) about z
    always_comb begin
        case (pay_reg[QSEL-1].axis)
            AXIS_X: begin
                a_next = pay_reg[QSEL-1].y;
                b_next = pay_reg[QSEL-1].z;
            end
            AXIS_Y: begin
                a_next = pay_reg[QSEL-1].z;
                b_next = pay_reg[QSEL-1].x;
            end
            default: begin
                a_next = pay_reg[QSEL-1].x;
                b_next = pay_reg[QSEL-1].y;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
            nsin_reg <= -sin_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
        end
    end

    // a' = a*c - b*s
    avr_mac #(
        .COMPONENT_WIDTH (CW)
    ) u_mac_a (
        .aclk   (aclk),
        .en     (en),
        .p      (a_reg),
        .u      (cos_reg),
        .q      (b_reg),
        .v      (nsin_reg),
        .result (r0),
        .sat    (sat0)
    );

    // b' = a*s + b*c
    avr_mac #(
        .COMPONENT_WIDTH (CW)
    ) u_mac_b (
        .aclk   (aclk),
        .en     (en),
        .p      (a_reg),
        .u      (sin_reg),
        .q      (b_reg),
        .v      (cos_reg),
        .result (r1),
        .sat    (sat1)
    );

    assign pay_out = pay_reg[DEPTH-1];

    always_comb begin
        m_out_x          = pay_out.x;
        m_out_y          = pay_out.y;
        m_out_z          = pay_out.z;
        m_saturated_flag = sat0 | sat1;
        case (pay_out.axis)
            AXIS_X: begin
                m_out_y = r0;
                m_out_z = r1;
            end
            AXIS_Y: begin
                m_out_z = r0;
                m_out_x = r1;
            end
            AXIS_Z: begin
                m_out_x = r0;
                m_out_y = r1;
            end
            default: begin
                m_saturated_flag = 1'b0;
            end
        endcase
    end

    // an accepted transaction enters the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    // a stalled result freezes every stage
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(valid_reg))
        else $error("pipeline moved while output stalled");

    // a clipped result carries a rail value
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated_flag) |->
            (m_out_x == SMAX || m_out_x == SMIN || m_out_y == SMAX ||
             m_out_y == SMIN || m_out_z == SMAX || m_out_z == SMIN))
        else $error("saturated flag without a clipped component");

    // the rotation axis component passes through, checked for rotation about y
    a_axis_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && pay_out.axis == AXIS_Y) |-> (m_out_y == pay_out.y))
        else $error("axis component changed by rotation");

endmodule

FILE: hdl/avr_cordic_stage.sv
// one registered rotation-mode cordic micro-rotation
// depends on avr_pkg (cordic_t, atan_entry)
module avr_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  avr_pkg::cordic_t d_in,
    output avr_pkg::cordic_t d_out
);
    import avr_pkg::*;

    cordic_t                  d_next;
    cordic_t                  d_reg;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic [ANGLE_Z_W-1:0]     step;

    always_comb begin
        dx   = d_in.y >>> STAGE;
        dy   = d_in.x >>> STAGE;
        step = ANGLE_Z_W'(atan_entry(5'(STAGE)));
        d_next.quad = d_in.quad;
        // rotate toward zero residual; non-negative residual turns positive
        if (!d_in.z[ANGLE_Z_W-1]) begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - $signed(step);
        end else begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + $signed(step);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

FILE: hdl/avr_mac.sv
// three-stage p*u + q*v with round half up from Q2.30 and saturation to the component width
// depends on avr_pkg (TRIG_W, TRIG_FRAC, ROUND_HALF)
module avr_mac #(
    parameter int COMPONENT_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [COMPONENT_WIDTH-1:0] p,
    input  logic signed [avr_pkg::TRIG_W-1:0] u,
    input  logic signed [COMPONENT_WIDTH-1:0] q,
    input  logic signed [avr_pkg::TRIG_W-1:0] v,
    output logic signed [COMPONENT_WIDTH-1:0] result,
    output logic                              sat
);
    import avr_pkg::*;

    localparam int CW    = COMPONENT_WIDTH;
    localparam int HI_W  = (CW > 16) ? CW - 16 : 1;
    localparam int PH_W  = HI_W + TRIG_W;
    localparam int PL_W  = 17 + TRIG_W;
    localparam int HS_W  = PH_W + 1;
    localparam int LS_W  = PL_W + 2;
    localparam int TW    = CW + 36;
    localparam int SH_W  = TW - TRIG_FRAC;

    logic signed [HI_W-1:0] ph, qh;
    logic signed [16:0]     pl, ql;

    logic signed [PH_W-1:0] pp_hi_p_reg, pp_hi_q_reg;
    logic signed [PL_W-1:0] pp_lo_p_reg, pp_lo_q_reg;
    logic signed [HS_W-1:0] hi_next, hi_reg;
    logic signed [LS_W-1:0] lo_next, lo_reg;
    logic signed [TW-1:0]   total;
    logic [SH_W-1:0]        shifted;
    logic [SH_W-CW:0]       top_bits;
    logic [CW-1:0]          result_next, result_reg;
    logic                   sat_next, sat_reg;

    // split each component into a signed high part and an unsigned low 16 bits
    assign ph = HI_W'(p >>> 16);
    assign qh = HI_W'(q >>> 16);
    assign pl = $signed({1'b0, p[15:0]});
    assign ql = $signed({1'b0, q[15:0]});

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_hi_p_reg <= ph * u;
            pp_hi_q_reg <= qh * v;
            pp_lo_p_reg <= pl * u;
            pp_lo_q_reg <= ql * v;
        end
    end

    assign hi_next = HS_W'(pp_hi_p_reg) + HS_W'(pp_hi_q_reg);
    assign lo_next = LS_W'(pp_lo_p_reg) + LS_W'(pp_lo_q_reg) + LS_W'(ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_comb begin
        total    = (TW'(hi_reg) <<< 16) + TW'(lo_reg);
        shifted  = total[TW-1:TRIG_FRAC];
        top_bits = shifted[SH_W-1:CW-1];
        if ((&top_bits) || !(|top_bits)) begin
            result_next = shifted[CW-1:0];
            sat_next    = 1'b0;
        end else begin
            result_next = shifted[SH_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            sat_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result = $signed(result_reg);
    assign sat    = sat_reg;

endmodule
